// File: hdl/nearest_request_disk_scheduler_defines.svh
// assertion macros for the nearest request disk scheduler
// no dependencies; included by the top level
`ifndef NEAREST_REQUEST_DISK_SCHEDULER_DEFINES_SVH
`define NEAREST_REQUEST_DISK_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NRDS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define NRDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/nrds_pkg.sv
// shared types and constants of the nearest request disk scheduler
// no dependencies; used by nrds_sel and the top level
`default_nettype none

package nrds_pkg;

    // width of the running seek total
    localparam int TOTAL_BITS = 32;

    typedef enum logic [1:0] {
        OP_EMPTY   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_RESTART = 2'd2,
        OP_SERVE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_CLEAR,
        S_FIN
    } t_state;

    // control from the sequencer to the nearest-entry selector
    typedef struct packed {
        logic clr;
        logic cmp;
    } t_sel_ctrl;

endpackage

`default_nettype wire

// File: hdl/nrds_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module nrds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/nrds_sel.sv
// nearest unserved entry selector, fed one table entry per cycle
// depends on nrds_pkg
`default_nettype none

module nrds_sel #(
    parameter int TRACK_BITS = 16,
    parameter int IDX_BITS   = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire nrds_pkg::t_sel_ctrl   i_ctrl,
    input  wire logic                  i_mark,
    input  wire logic [TRACK_BITS-1:0] i_track,
    input  wire logic [TRACK_BITS-1:0] i_head,
    input  wire logic [IDX_BITS-1:0]   i_idx,
    output logic                       o_found,
    output logic [IDX_BITS-1:0]        o_best_idx,
    output logic [TRACK_BITS-1:0]      o_best_track,
    output logic [TRACK_BITS-1:0]      o_best_dist
);

    logic                  r_found;
    logic [IDX_BITS-1:0]   r_best_idx;
    logic [TRACK_BITS-1:0] r_best_track;
    logic [TRACK_BITS-1:0] r_best_dist;
    logic [TRACK_BITS-1:0] cand_dist;
    logic                  take;

    // absolute distance from the head; strict compare keeps the lowest index on ties
    always_comb begin
        cand_dist = (i_track >= i_head) ? (i_track - i_head) : (i_head - i_track);
        take = i_ctrl.cmp && !i_mark && (!r_found || (cand_dist < r_best_dist));
    end

    // found flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctrl.clr) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    // best candidate payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_idx   <= i_idx;
            r_best_track <= i_track;
            r_best_dist  <= cand_dist;
        end
    end

    assign o_found      = r_found;
    assign o_best_idx   = r_best_idx;
    assign o_best_track = r_best_track;
    assign o_best_dist  = r_best_dist;

endmodule

`default_nettype wire

// File: hdl/nearest_request_disk_scheduler.sv
// Shortest-seek-time-first scheduler. Each item carries an opcode: empty the table, append a
// track, restart a pass (clear served marks and total) or serve the nearest unserved track.
// Exactly one result item follows each input item. Restart and serve sweep the table one
// entry per cycle: restart clears the served marks, and serve reads the track and
// served-mark memories through their single read port.
// A new item is taken while a previous result still waits at the output register.
// depends on nrds_pkg, nrds_ram, nrds_sel and nearest_request_disk_scheduler_defines.svh
`default_nettype none
`include "nearest_request_disk_scheduler_defines.svh"

module nearest_request_disk_scheduler #(
    parameter int MAX_REQUESTS = 64,
    parameter int TRACK_BITS   = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [TRACK_BITS-1:0] i_track,
    input  wire logic [TRACK_BITS-1:0] i_head_pos,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [1:0]                 o_status,
    output logic [TRACK_BITS-1:0]      o_served_track,
    output logic [TRACK_BITS-1:0]      o_seek_distance,
    output logic [31:0]                o_total_seek
);

    localparam int AW = $clog2(MAX_REQUESTS);
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int TW = nrds_pkg::TOTAL_BITS;

    nrds_pkg::t_state    r_state;
    nrds_pkg::t_state    n_state;
    nrds_pkg::t_op       r_op;
    logic [TRACK_BITS-1:0] r_track;
    logic [TRACK_BITS-1:0] r_head;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_addr;
    logic                r_cmp_pend;
    logic [AW-1:0]       r_cmp_idx;
    logic [TW-1:0]       r_total;
    logic                r_out_valid;
    nrds_pkg::t_status   r_out_status;
    logic [TRACK_BITS-1:0] r_out_track;
    logic [TRACK_BITS-1:0] r_out_dist;
    logic [TW-1:0]       r_out_total;
    nrds_pkg::t_status   n_out_status;
    logic [TRACK_BITS-1:0] n_out_track;
    logic [TRACK_BITS-1:0] n_out_dist;
    logic [TW-1:0]       n_out_total;

    logic                accept;
    logic                out_free;
    logic                scan_rd;
    logic                clr_we;
    logic                fin_go;
    logic                full;
    logic                app_we;
    logic                serve_we;
    logic                mark_we;
    logic [AW-1:0]       mark_waddr;
    logic                mark_rdata;
    logic [TRACK_BITS-1:0] track_rdata;
    logic [TW-1:0]       sum_total;
    nrds_pkg::t_sel_ctrl sel_ctrl;
    logic                found;
    logic [AW-1:0]       best_idx;
    logic [TRACK_BITS-1:0] best_track;
    logic [TRACK_BITS-1:0] best_dist;

    // handshake terms
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign full     = (r_count == CW'(MAX_REQUESTS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nrds_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (nrds_pkg::t_op'(i_opcode))
                        nrds_pkg::OP_SERVE:   n_state = nrds_pkg::S_SCAN;
                        nrds_pkg::OP_RESTART: n_state = nrds_pkg::S_CLEAR;
                        default:              n_state = nrds_pkg::S_FIN;
                    endcase
                end
            end
            nrds_pkg::S_SCAN: begin
                if (r_addr == r_count) n_state = nrds_pkg::S_TAIL;
            end
            nrds_pkg::S_TAIL: begin
                n_state = nrds_pkg::S_FIN;
            end
            nrds_pkg::S_CLEAR: begin
                if (r_addr == r_count) n_state = nrds_pkg::S_FIN;
            end
            nrds_pkg::S_FIN: begin
                if (out_free) n_state = nrds_pkg::S_IDLE;
            end
            default: n_state = nrds_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_ready      = (r_state == nrds_pkg::S_IDLE);
        scan_rd      = (r_state == nrds_pkg::S_SCAN) && (r_addr != r_count);
        clr_we       = (r_state == nrds_pkg::S_CLEAR) && (r_addr != r_count);
        fin_go       = (r_state == nrds_pkg::S_FIN) && out_free;
        sel_ctrl.clr = (r_state == nrds_pkg::S_IDLE) && i_valid;
        sel_ctrl.cmp = r_cmp_pend;
    end

    // memory write selection
    always_comb begin
        app_we   = fin_go && (r_op == nrds_pkg::OP_APPEND) && !full;
        serve_we = fin_go && (r_op == nrds_pkg::OP_SERVE) && found;
        mark_we  = clr_we || app_we || serve_we;
        priority if (serve_we) begin
            mark_waddr = best_idx;
        end else if (app_we) begin
            mark_waddr = r_count[AW-1:0];
        end else begin
            mark_waddr = r_addr[AW-1:0];
        end
        sum_total = r_total + TW'(best_dist);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nrds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latched item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= nrds_pkg::t_op'(i_opcode);
            r_track <= i_track;
            r_head  <= i_head_pos;
        end
    end

    // sweep address and read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_cmp_pend <= 1'b0;
        end else begin
            if (accept) begin
                r_addr <= '0;
            end else if (scan_rd || clr_we) begin
                r_addr <= r_addr + CW'(1);
            end
            r_cmp_pend <= scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr[AW-1:0];
    end

    // table count and seek total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
        end else if (fin_go) begin
            unique case (r_op)
                nrds_pkg::OP_EMPTY: begin
                    r_count <= '0;
                    r_total <= '0;
                end
                nrds_pkg::OP_APPEND: begin
                    if (!full) r_count <= r_count + CW'(1);
                end
                nrds_pkg::OP_RESTART: begin
                    r_total <= '0;
                end
                nrds_pkg::OP_SERVE: begin
                    if (found) r_total <= sum_total;
                end
                default: ;
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload of the item being finished
    always_comb begin
        n_out_status = nrds_pkg::ST_OK;
        n_out_track  = '0;
        n_out_dist   = '0;
        n_out_total  = r_total;
        unique case (r_op)
            nrds_pkg::OP_EMPTY: begin
                n_out_total = '0;
            end
            nrds_pkg::OP_APPEND: begin
                if (full) n_out_status = nrds_pkg::ST_FULL;
            end
            nrds_pkg::OP_RESTART: begin
                n_out_total = '0;
            end
            nrds_pkg::OP_SERVE: begin
                if (found) begin
                    n_out_track = best_track;
                    n_out_dist  = best_dist;
                    n_out_total = sum_total;
                end else begin
                    n_out_status = nrds_pkg::ST_NONE;
                end
            end
            default: ;
        endcase
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out_status <= n_out_status;
            r_out_track  <= n_out_track;
            r_out_dist   <= n_out_dist;
            r_out_total  <= n_out_total;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_served_track  = r_out_track;
    assign o_seek_distance = r_out_dist;
    assign o_total_seek    = r_out_total;

    // request track memory
    nrds_ram #(
        .WIDTH (TRACK_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_track_ram (
        .i_clk   (i_clk),
        .i_we    (app_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_track),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (track_rdata)
    );

    // served mark memory
    nrds_ram #(
        .WIDTH (1),
        .DEPTH (MAX_REQUESTS)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (serve_we),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (mark_rdata)
    );

    // nearest unserved entry selection
    nrds_sel #(
        .TRACK_BITS (TRACK_BITS),
        .IDX_BITS   (AW)
    ) u_sel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (sel_ctrl),
        .i_mark       (mark_rdata),
        .i_track      (track_rdata),
        .i_head       (r_head),
        .i_idx        (r_cmp_idx),
        .o_found      (found),
        .o_best_idx   (best_idx),
        .o_best_track (best_track),
        .o_best_dist  (best_dist)
    );

    // checks
    `NRDS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_REQUESTS), "count above table depth")
    `NRDS_ASSERT_NOW(a_sweep_bound, i_clk, i_rst_n, r_state != nrds_pkg::S_IDLE, r_addr <= r_count, "sweep address past count")
    `NRDS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != nrds_pkg::S_IDLE, "accepted item left no work")
    `NRDS_ASSERT_NOW(a_none_zero, i_clk, i_rst_n, r_out_valid && (r_out_status == nrds_pkg::ST_NONE), (r_out_track == '0) && (r_out_dist == '0), "empty serve reports a track")

endmodule

`default_nettype wire

// File: dv/nearest_request_disk_scheduler_tb.sv
// self-checking testbench for the nearest request disk scheduler: directed corner cases,
// a full-table pass and random request passes under several sender and receiver idling mixes
// depends on nrds_pkg and the nearest_request_disk_scheduler top level
`timescale 1ns / 1ps

module nearest_request_disk_scheduler_tb;

    import nrds_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int TRK_W       = 16;

    typedef struct packed {
        t_status               status;
        logic [TRK_W-1:0]      track;
        logic [TRK_W-1:0]      distance;
        logic [TOTAL_BITS-1:0] total;
    } sched_result_t;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic [1:0]       i_opcode   = OP_EMPTY;
    logic [TRK_W-1:0] i_track    = '0;
    logic [TRK_W-1:0] i_head_pos = '0;
    logic             i_ready    = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [1:0]       o_status;
    logic [TRK_W-1:0] o_served_track;
    logic [TRK_W-1:0] o_seek_distance;
    logic [31:0]      o_total_seek;

    // scheduler state as the checker sees it
    logic [TRK_W-1:0]       track_table [TABLE_DEPTH];
    bit [TABLE_DEPTH-1:0]   served_flags = '0;
    int                     table_fill   = 0;
    logic [TOTAL_BITS-1:0]  seek_sum     = '0;

    sched_result_t due_results[$];

    int idle_pct    = 0;
    int stall_pct   = 0;
    int stall_burst = 0;
    int err_count   = 0;
    int n_items     = 0;
    int n_checked   = 0;
    int n_served    = 0;
    int n_refused   = 0;
    int n_full      = 0;
    int n_ties      = 0;
    int n_passes    = 0;

    nearest_request_disk_scheduler #(
        .MAX_REQUESTS (TABLE_DEPTH),
        .TRACK_BITS   (TRK_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_track         (i_track),
        .i_head_pos      (i_head_pos),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_served_track  (o_served_track),
        .o_seek_distance (o_seek_distance),
        .o_total_seek    (o_total_seek)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("nearest_request_disk_scheduler_tb NOT OK");
        $finish;
    end

    // apply one item to the tracked state and return the result it should produce
    function automatic sched_result_t schedule_step(t_op op, logic [TRK_W-1:0] trk,
                                                    logic [TRK_W-1:0] head);
        sched_result_t r;
        int            best;
        logic [TRK_W-1:0] best_d;
        logic [TRK_W-1:0] d;
        r.status   = ST_OK;
        r.track    = '0;
        r.distance = '0;
        best       = -1;
        best_d     = '0;
        case (op)
            OP_EMPTY: begin
                table_fill   = 0;
                served_flags = '0;
                seek_sum     = '0;
            end
            OP_APPEND: begin
                if (table_fill >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    track_table[table_fill]  = trk;
                    served_flags[table_fill] = 1'b0;
                    table_fill++;
                end
            end
            OP_RESTART: begin
                served_flags = '0;
                seek_sum     = '0;
            end
            default: begin
                // nearest unserved entry, first one kept on equal distance
                for (int i = 0; i < table_fill; i++) begin
                    if (!served_flags[i]) begin
                        d = (track_table[i] >= head) ? track_table[i] - head
                                                     : head - track_table[i];
                        if (best >= 0 && d == best_d)
                            n_ties++;
                        if (best < 0 || d < best_d) begin
                            best   = i;
                            best_d = d;
                        end
                    end
                end
                if (best < 0) begin
                    r.status = ST_NONE;
                    n_refused++;
                end else begin
                    served_flags[best] = 1'b1;
                    seek_sum           = seek_sum + best_d;
                    r.track            = track_table[best];
                    r.distance         = best_d;
                    n_served++;
                end
            end
        endcase
        r.total = seek_sum;
        return r;
    endfunction

    // send one item, with random idle cycles ahead of it
    task automatic send_item(t_op op, logic [TRK_W-1:0] trk, logic [TRK_W-1:0] head);
        int gap;
        gap = 0;
        if (idle_pct > 0) begin
            if ($urandom_range(15) == 0)
                gap = $urandom_range(1, 80);
            else
                while ($urandom_range(99) < idle_pct) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_track    <= trk;
        i_head_pos <= head;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        due_results.push_back(schedule_step(op, trk, head));
        n_items++;
    endtask

    // hold off the sender until every owed result has been seen
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stalls plus checking against the oldest owed result
    always @(posedge i_clk) begin
        sched_result_t exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                $error("result item with no item outstanding: status %0d track %0d",
                       o_status, o_served_track);
                err_count++;
            end else begin
                exp_r = due_results.pop_front();
                n_checked++;
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    err_count++;
                end
                if (o_served_track !== exp_r.track) begin
                    $error("served_track: expected %0d, got %0d", exp_r.track,
                           o_served_track);
                    err_count++;
                end
                if (o_seek_distance !== exp_r.distance) begin
                    $error("seek_distance: expected %0d, got %0d", exp_r.distance,
                           o_seek_distance);
                    err_count++;
                end
                if (o_total_seek !== exp_r.total) begin
                    $error("total_seek: expected %0d, got %0d", exp_r.total, o_total_seek);
                    err_count++;
                end
            end
        end
        if (stall_burst > 0) begin
            stall_burst = stall_burst - 1;
            i_ready <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(63) == 0) begin
            stall_burst = $urandom_range(1, 70);
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // random track number cut to the track width
    function automatic logic [TRK_W-1:0] rand_trk();
        return TRK_W'($urandom);
    endfunction

    // tracks often clustered near a base so that equal distances turn up, else random or extreme
    function automatic logic [TRK_W-1:0] pick_track(logic [TRK_W-1:0] base);
        int mode;
        mode = $urandom_range(9);
        if (mode < 4)
            return rand_trk();
        else if (mode < 8)
            return base + TRK_W'($urandom_range(0, 31));
        else if (mode == 8)
            return '0;
        else
            return '1;
    endfunction

    // empty table, extremes, ties, restart and refused serves
    task automatic test_directed_cases();
        send_item(OP_SERVE,   rand_trk(), 16'h0000);
        send_item(OP_APPEND,  16'hFFFF, rand_trk());
        send_item(OP_APPEND,  16'h0000, rand_trk());
        send_item(OP_APPEND,  16'd100,  rand_trk());
        send_item(OP_APPEND,  16'd100,  rand_trk());
        send_item(OP_APPEND,  16'd200,  rand_trk());
        send_item(OP_SERVE,   rand_trk(), 16'd150);
        send_item(OP_SERVE,   rand_trk(), 16'd150);
        send_item(OP_SERVE,   rand_trk(), 16'hFFFF);
        send_item(OP_SERVE,   rand_trk(), 16'h8000);
        send_item(OP_SERVE,   rand_trk(), 16'hFFFF);
        send_item(OP_SERVE,   rand_trk(), 16'h0000);
        send_item(OP_RESTART, rand_trk(), rand_trk());
        send_item(OP_SERVE,   rand_trk(), 16'h0000);
        wait_drained();
        send_item(OP_EMPTY,   rand_trk(), rand_trk());
        send_item(OP_SERVE,   rand_trk(), 16'hFFFF);
        send_item(OP_APPEND,  16'h1234, rand_trk());
        send_item(OP_SERVE,   rand_trk(), 16'h1234);
    endtask

    // fill every entry, push past the end, then serve and restart
    task automatic test_full_table();
        logic [TRK_W-1:0] base;
        base = rand_trk();
        send_item(OP_EMPTY, rand_trk(), rand_trk());
        repeat (TABLE_DEPTH + 2) send_item(OP_APPEND, pick_track(base), rand_trk());
        repeat (6) send_item(OP_SERVE, rand_trk(), pick_track(base));
        send_item(OP_RESTART, rand_trk(), rand_trk());
        repeat (3) send_item(OP_SERVE, rand_trk(), pick_track(base));
    endtask

    // one pass: empty, append a batch, serve it out and sometimes beyond, maybe restart
    task automatic run_pass();
        int               n_app;
        int               n_srv;
        int               pick;
        logic [TRK_W-1:0] base;
        base = rand_trk();
        pick = $urandom_range(19);
        if (pick == 0)
            n_app = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 4);
        else if (pick < 4)
            n_app = $urandom_range(9, 40);
        else
            n_app = $urandom_range(0, 8);
        n_srv = ((n_app > TABLE_DEPTH) ? TABLE_DEPTH : n_app) + $urandom_range(0, 2);
        send_item(OP_EMPTY, rand_trk(), rand_trk());
        repeat (n_app) send_item(OP_APPEND, pick_track(base), rand_trk());
        repeat (n_srv) send_item(OP_SERVE, rand_trk(), pick_track(base));
        if ($urandom_range(2) == 0) begin
            send_item(OP_RESTART, rand_trk(), rand_trk());
            repeat ($urandom_range(1, 4)) send_item(OP_SERVE, rand_trk(), pick_track(base));
        end
        n_passes++;
    endtask

    // random passes mixed with loose items under one idling mix
    task automatic test_random_traffic(int idle, int stall, int count);
        int start;
        idle_pct  = idle;
        stall_pct = stall;
        start     = n_items;
        while (n_items - start < count) begin
            if ($urandom_range(9) == 0)
                wait_drained();
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 4))
                    send_item(t_op'($urandom_range(3)), rand_trk(), rand_trk());
            else
                run_pass();
        end
    endtask

    // drain, let the block settle, then report
    task automatic finish_run();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 16) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d result items never arrived", due_results.size());
            err_count++;
        end
        $display("%0d items sent in %0d random passes, %0d results checked",
                 n_items, n_passes, n_checked);
        $display("serves: %0d found, %0d with nothing pending, %0d ties; %0d appends refused",
                 n_served, n_refused, n_ties, n_full);
        if (err_count == 0)
            $display("nearest_request_disk_scheduler_tb OK");
        else
            $display("nearest_request_disk_scheduler_tb NOT OK");
        $finish;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_full_table();
        test_random_traffic(0, 0, 385);
        test_random_traffic(53, 0, 385);
        test_random_traffic(0, 53, 385);
        test_random_traffic(33, 33, 385);
        finish_run();
    end

endmodule
